>>> rtl/core/direction_to_orthonormal_basis_defines.svh
// ----------------------------------------------------------------------------
// direction_to_orthonormal_basis assertion macros
// shared property forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef DIRECTION_TO_ORTHONORMAL_BASIS_DEFINES_SVH
`define DIRECTION_TO_ORTHONORMAL_BASIS_DEFINES_SVH

// same-cycle implication
`define DTOB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DTOB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/dtob_pkg.sv
// ----------------------------------------------------------------------------
// dtob_pkg
// widths, payload types and fixed-point helpers of the basis pipeline
// ----------------------------------------------------------------------------
package dtob_pkg;

	localparam int FRAC_BITS = 14;
	localparam int IO_W      = 16;
	localparam int CS_W      = FRAC_BITS + 2;     // cosine / sine, [-1, 1]
	localparam int T_W       = CS_W + 1;          // 1 - c2, [0, 2]
	localparam int M_W       = CS_W + 2;          // rotation matrix entries
	localparam int LEN_W     = IO_W;
	localparam int SQ_W      = 2 * IO_W;
	localparam int ARG_W     = 2 * FRAC_BITS + 2;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int NUM_W     = IO_W + FRAC_BITS;
	localparam int RND_W     = 40;
	localparam int FX_ONE    = 1 << FRAC_BITS;
	localparam int OUT_LIM   = (FX_ONE < 32767) ? FX_ONE : 32767;

	localparam logic [RND_W-1:0] FX_HALF = RND_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [2*CS_W-1:0] FX_ONE_SQ = (2*CS_W)'(1) << (2 * FRAC_BITS);
	localparam logic signed [IO_W-1:0] OUT_ONE = IO_W'(OUT_LIM);

	typedef struct packed {
		logic signed [IO_W-1:0] dir_x;
		logic signed [IO_W-1:0] dir_y;
		logic signed [IO_W-1:0] dir_z;
	} dtob_dir_t;

	typedef struct packed {
		logic signed [IO_W-1:0] axis1_x;
		logic signed [IO_W-1:0] axis1_y;
		logic signed [IO_W-1:0] axis1_z;
		logic signed [IO_W-1:0] axis2_x;
		logic signed [IO_W-1:0] axis2_y;
		logic signed [IO_W-1:0] axis2_z;
		logic signed [IO_W-1:0] axis3_x;
		logic signed [IO_W-1:0] axis3_y;
		logic signed [IO_W-1:0] axis3_z;
		logic                   degenerate;
	} dtob_basis_t;

	// product back to FRAC_BITS, half away from zero
	function automatic logic signed [RND_W-1:0] fx_round(input logic signed [RND_W-1:0] p);
		logic [RND_W-1:0] mag;
		logic [RND_W-1:0] q;
		mag = p[RND_W-1] ? -p : p;
		q = (mag + FX_HALF) >> FRAC_BITS;
		return p[RND_W-1] ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic signed [RND_W-1:0] fx_sat(input logic signed [RND_W-1:0] v,
		input int lim);
		logic signed [RND_W-1:0] l;
		l = RND_W'(lim);
		if (v > l)
			return l;
		if (v < -l)
			return -l;
		return v;
	endfunction

	function automatic logic signed [IO_W-1:0] fx_out(input logic signed [RND_W-1:0] v);
		logic signed [RND_W-1:0] s;
		s = fx_sat(v, OUT_LIM);
		return s[IO_W-1:0];
	endfunction

	// 1 - c^2, clamped at zero
	function automatic logic [ARG_W-1:0] fx_sine_arg(input logic signed [CS_W-1:0] c);
		logic signed [2*CS_W-1:0] sq;
		logic signed [2*CS_W-1:0] diff;
		sq = c * c;
		diff = FX_ONE_SQ - sq;
		return diff[2*CS_W-1] ? '0 : diff[ARG_W-1:0];
	endfunction

endpackage

>>> rtl/core/dtob_isqrt.sv
// ----------------------------------------------------------------------------
// dtob_isqrt
// pipelined floor square root, one root bit per stage, side data carried along
// ----------------------------------------------------------------------------
module dtob_isqrt #(
	parameter int RAD_W  = 32,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [RAD_W-1:0]      in_rad,
	input  logic [SIDE_W-1:0]     in_side,
	output logic                  out_valid,
	output logic [RAD_W/2-1:0]    out_root,
	output logic [SIDE_W-1:0]     out_side
);

	localparam int STEPS = RAD_W / 2;

	logic [STEPS:0]    valid_s;
	logic [RAD_W-1:0]  rad_s  [STEPS+1];
	logic [RAD_W-1:0]  root_s [STEPS+1];
	logic [SIDE_W-1:0] side_s [STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s[0]  <= in_rad;
			root_s[0] <= '0;
			side_s[0] <= in_side;
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (2 * (STEPS - 1 - k));
		logic [RAD_W:0] trial;
		logic           take;

		assign trial = {1'b0, root_s[k]} + BIT;
		assign take  = {1'b0, rad_s[k]} >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				if (take) begin
					rad_s[k+1]  <= rad_s[k] - trial[RAD_W-1:0];
					root_s[k+1] <= (root_s[k] >> 1) + BIT[RAD_W-1:0];
				end else begin
					rad_s[k+1]  <= rad_s[k];
					root_s[k+1] <= root_s[k] >> 1;
				end
			end
		end
	end

	assign out_valid = valid_s[STEPS];
	assign out_root  = root_s[STEPS][STEPS-1:0];
	assign out_side  = side_s[STEPS];

endmodule

>>> rtl/core/direction_to_orthonormal_basis.sv
// ----------------------------------------------------------------------------
// direction_to_orthonormal_basis
// rotated orthonormal basis from a Q2.14 direction, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   dir channel (in_valid / in_ready / dir): one direction per transfer,
//   three signed Q2.14 components
//   basis channel (out_valid / out_ready / basis): three basis vectors in
//   signed Q2.14 plus the degenerate flag, one result per direction
// depth: the pipeline length is set by the three bit-serial square roots
//   (16 + 15 + 15 stages) and the 15-stage divider
// throughput: one direction per cycle while the receiver takes results
// degenerate: a direction with x and z both zero gives the identity basis
//   with degenerate set
// reset: arst_n clears every stage valid bit, so the pipeline comes up empty
// stall: the whole pipeline advances on one enable; when the output register
//   holds a result the receiver has not taken, all stages freeze and in_ready
//   drops, so nothing is lost or repeated
// ----------------------------------------------------------------------------
`include "direction_to_orthonormal_basis_defines.svh"

module direction_to_orthonormal_basis
	import dtob_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  dtob_dir_t   dir,
	output logic        out_valid,
	input  logic        out_ready,
	output dtob_basis_t basis
);

	typedef struct packed {
		logic                   deg;
		logic signed [IO_W-1:0] x;
		logic signed [IO_W-1:0] y;
		logic signed [IO_W-1:0] z;
	} xyz_side_t;

	typedef struct packed {
		logic                   deg;
		logic signed [IO_W-1:0] x;
		logic signed [IO_W-1:0] y;
		logic signed [IO_W-1:0] z;
		logic signed [CS_W-1:0] c1;
	} c1_side_t;

	typedef struct packed {
		logic                   deg;
		logic                   yneg;
		logic signed [CS_W-1:0] c1;
		logic signed [CS_W-1:0] s1;
		logic signed [CS_W-1:0] c2;
	} c2_side_t;

	// one enable for the whole pipeline
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// ---------------- s1: input register ----------------
	logic                   valid_s1;
	logic signed [IO_W-1:0] x_s1, y_s1, z_s1;
	logic signed [SQ_W-1:0] xx, zz;
	logic [SQ_W-1:0]        sq;
	xyz_side_t              side1_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= dir.dir_x;
			y_s1 <= dir.dir_y;
			z_s1 <= dir.dir_z;
		end
	end

	// squared length of the xz projection
	assign xx = x_s1 * x_s1;
	assign zz = z_s1 * z_s1;
	assign sq = xx + zz;

	assign side1_in = '{deg: (x_s1 == '0) && (z_s1 == '0), x: x_s1, y: y_s1, z: z_s1};

	// ---------------- projection length ----------------
	logic             len_valid;
	logic [LEN_W-1:0] len_root;
	xyz_side_t        side1_out;

	dtob_isqrt #(
		.RAD_W  (SQ_W),
		.SIDE_W ($bits(xyz_side_t))
	) u_len_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s1),
		.in_rad    (sq),
		.in_side   (side1_in),
		.out_valid (len_valid),
		.out_root  (len_root),
		.out_side  (side1_out)
	);

	// ---------------- c1 = z / len, restoring divider on |z| ----------------
	logic [IO_W-1:0]  az;
	logic [NUM_W-1:0] num_in;

	logic [QUO_W:0]   dv_s;
	logic [NUM_W-1:0] num_s  [QUO_W+1];
	logic [LEN_W-1:0] rem_s  [QUO_W+1];
	logic [LEN_W-1:0] dlen_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s  [QUO_W+1];
	xyz_side_t        dside_s[QUO_W+1];

	assign az     = side1_out.z[IO_W-1] ? IO_W'(-side1_out.z) : IO_W'(side1_out.z);
	// rounding half up by adding len / 2 ahead of the division
	assign num_in = (NUM_W'(az) << FRAC_BITS) + NUM_W'(len_root >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s <= '0;
		end else if (adv) begin
			dv_s <= {dv_s[QUO_W-1:0], len_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s[0]   <= num_in;
			rem_s[0]   <= LEN_W'(num_in >> QUO_W);
			dlen_s[0]  <= len_root;
			quo_s[0]   <= '0;
			dside_s[0] <= side1_out;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [LEN_W:0] part;
		logic           take;

		assign part = {rem_s[k], num_s[k][QUO_W-1-k]};
		assign take = part >= {1'b0, dlen_s[k]};

		always_ff @(posedge clk) begin
			if (adv) begin
				num_s[k+1]   <= num_s[k];
				dlen_s[k+1]  <= dlen_s[k];
				dside_s[k+1] <= dside_s[k];
				quo_s[k+1]   <= {quo_s[k][QUO_W-2:0], take};
				rem_s[k+1]   <= take ? LEN_W'(part - {1'b0, dlen_s[k]}) : LEN_W'(part);
			end
		end
	end

	logic [QUO_W-1:0]       quo_clamp;
	logic signed [CS_W-1:0] c1_mag;
	logic signed [CS_W-1:0] c1_in;
	xyz_side_t              dside_out;

	assign dside_out = dside_s[QUO_W];
	assign quo_clamp = (quo_s[QUO_W] > QUO_W'(FX_ONE)) ? QUO_W'(FX_ONE) : quo_s[QUO_W];
	assign c1_mag    = $signed(CS_W'(quo_clamp));
	assign c1_in     = dside_out.z[IO_W-1] ? -c1_mag : c1_mag;

	// ---------------- s2: c1 register ----------------
	logic     valid_s2;
	c1_side_t c1_side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= dv_s[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c1_side_s2 <= '{deg: dside_out.deg, x: dside_out.x, y: dside_out.y,
				z: dside_out.z, c1: c1_in};
		end
	end

	// ---------------- s1 sine ----------------
	logic                s1_valid;
	logic [ARG_W/2-1:0]  s1_root;
	c1_side_t            side2_out;

	dtob_isqrt #(
		.RAD_W  (ARG_W),
		.SIDE_W ($bits(c1_side_t))
	) u_s1_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s2),
		.in_rad    (fx_sine_arg(c1_side_s2.c1)),
		.in_side   (c1_side_s2),
		.out_valid (s1_valid),
		.out_root  (s1_root),
		.out_side  (side2_out)
	);

	logic signed [CS_W-1:0] s1_mag, s1_val;
	assign s1_mag = $signed(CS_W'(s1_root));
	assign s1_val = side2_out.x[IO_W-1] ? -s1_mag : s1_mag;

	// ---------------- s3: dot product terms for c2 ----------------
	logic                        valid_s3;
	logic signed [IO_W+CS_W-1:0] px_s3, pz_s3;
	logic signed [CS_W-1:0]      c1_s3, s1_s3;
	logic                        yneg_s3, deg_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s3   <= side2_out.x * s1_val;
			pz_s3   <= side2_out.z * side2_out.c1;
			c1_s3   <= side2_out.c1;
			s1_s3   <= s1_val;
			yneg_s3 <= side2_out.y[IO_W-1];
			deg_s3  <= side2_out.deg;
		end
	end

	// ---------------- s4: c2, saturated to [-1, 1] ----------------
	logic     valid_s4;
	c2_side_t c2_side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c2_side_s4 <= '{deg: deg_s3, yneg: yneg_s3, c1: c1_s3, s1: s1_s3,
				c2: CS_W'(fx_sat(fx_round(RND_W'(px_s3)) + fx_round(RND_W'(pz_s3)), FX_ONE))};
		end
	end

	// ---------------- s2 sine ----------------
	logic               s2_valid;
	logic [ARG_W/2-1:0] s2_root;
	c2_side_t           side3_out;

	dtob_isqrt #(
		.RAD_W  (ARG_W),
		.SIDE_W ($bits(c2_side_t))
	) u_s2_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s4),
		.in_rad    (fx_sine_arg(c2_side_s4.c2)),
		.in_side   (c2_side_s4),
		.out_valid (s2_valid),
		.out_root  (s2_root),
		.out_side  (side3_out)
	);

	logic signed [CS_W-1:0] s2_mag, s2_val;
	assign s2_mag = $signed(CS_W'(s2_root));
	assign s2_val = side3_out.yneg ? -s2_mag : s2_mag;

	// ---------------- s5: first-order matrix products ----------------
	// axis k = (c1, 0, -s1); the zero terms of the Rodrigues matrix drop out
	logic                      valid_s5;
	logic signed [2*CS_W-1:0]  pa_s5, pb_s5, pc_s5, pd_s5, pe_s5;
	logic signed [T_W-1:0]     t_s5;
	logic signed [CS_W-1:0]    c1_s5, s1_s5, c2_s5;
	logic                      deg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s5 <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pa_s5  <= side3_out.c1 * side3_out.c1;
			pb_s5  <= side3_out.c1 * side3_out.s1;
			pc_s5  <= side3_out.s1 * side3_out.s1;
			pd_s5  <= side3_out.s1 * s2_val;
			pe_s5  <= side3_out.c1 * s2_val;
			t_s5   <= T_W'(FX_ONE) - T_W'(side3_out.c2);
			c1_s5  <= side3_out.c1;
			s1_s5  <= side3_out.s1;
			c2_s5  <= side3_out.c2;
			deg_s5 <= side3_out.deg;
		end
	end

	// ---------------- s6: round first-order products ----------------
	logic                   valid_s6;
	logic signed [CS_W-1:0] a_s6, b_s6, cc_s6, d_s6, e_s6;
	logic signed [T_W-1:0]  t_s6;
	logic signed [CS_W-1:0] c1_s6, s1_s6, c2_s6;
	logic                   deg_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else if (adv) begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s6   <= CS_W'(fx_round(RND_W'(pa_s5)));
			b_s6   <= CS_W'(fx_round(RND_W'(pb_s5)));
			cc_s6  <= CS_W'(fx_round(RND_W'(pc_s5)));
			d_s6   <= CS_W'(fx_round(RND_W'(pd_s5)));
			e_s6   <= CS_W'(fx_round(RND_W'(pe_s5)));
			t_s6   <= t_s5;
			c1_s6  <= c1_s5;
			s1_s6  <= s1_s5;
			c2_s6  <= c2_s5;
			deg_s6 <= deg_s5;
		end
	end

	// ---------------- s7: scale by (1 - c2) ----------------
	logic                       valid_s7;
	logic signed [CS_W+T_W-1:0] at_s7, bt_s7, ct_s7;
	logic signed [CS_W-1:0]     d_s7, e_s7, c1_s7, s1_s7, c2_s7;
	logic                       deg_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			at_s7  <= a_s6 * t_s6;
			bt_s7  <= b_s6 * t_s6;
			ct_s7  <= cc_s6 * t_s6;
			d_s7   <= d_s6;
			e_s7   <= e_s6;
			c1_s7  <= c1_s6;
			s1_s7  <= s1_s6;
			c2_s7  <= c2_s6;
			deg_s7 <= deg_s6;
		end
	end

	// ---------------- s8: matrix entries ----------------
	// m01 = s1*s2, m11 = c2, m21 = c1*s2 are the second axis directly
	logic                   valid_s8;
	logic signed [M_W-1:0]  m00_s8, m02_s8, m10_s8, m12_s8, m22_s8;
	logic signed [CS_W-1:0] c1_s8, s1_s8;
	logic signed [IO_W-1:0] ax2x_s8, ax2y_s8, ax2z_s8;
	logic                   deg_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (adv) begin
			valid_s8 <= valid_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m00_s8  <= M_W'(RND_W'(c2_s7) + fx_round(RND_W'(at_s7)));
			m22_s8  <= M_W'(RND_W'(c2_s7) + fx_round(RND_W'(ct_s7)));
			m02_s8  <= M_W'(-fx_round(RND_W'(bt_s7)));   // m20 is the same
			m10_s8  <= -M_W'(d_s7);
			m12_s8  <= -M_W'(e_s7);
			c1_s8   <= c1_s7;
			s1_s8   <= s1_s7;
			ax2x_s8 <= fx_out(RND_W'(d_s7));
			ax2y_s8 <= fx_out(RND_W'(c2_s7));
			ax2z_s8 <= fx_out(RND_W'(e_s7));
			deg_s8  <= deg_s7;
		end
	end

	// ---------------- s9: apply matrix to axes 1 and 3 ----------------
	logic                       valid_s9;
	logic signed [M_W+CS_W-1:0] p00c_s9, p02s_s9, p10c_s9, p12s_s9, p20c_s9, p22s_s9;
	logic signed [M_W+CS_W-1:0] p00s_s9, p02c_s9, p10s_s9, p12c_s9, p20s_s9, p22c_s9;
	logic signed [IO_W-1:0]     ax2x_s9, ax2y_s9, ax2z_s9;
	logic                       deg_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (adv) begin
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p00c_s9 <= m00_s8 * c1_s8;
			p02s_s9 <= m02_s8 * s1_s8;
			p10c_s9 <= m10_s8 * c1_s8;
			p12s_s9 <= m12_s8 * s1_s8;
			p20c_s9 <= m02_s8 * c1_s8;
			p22s_s9 <= m22_s8 * s1_s8;
			p00s_s9 <= m00_s8 * s1_s8;
			p02c_s9 <= m02_s8 * c1_s8;
			p10s_s9 <= m10_s8 * s1_s8;
			p12c_s9 <= m12_s8 * c1_s8;
			p20s_s9 <= m02_s8 * s1_s8;
			p22c_s9 <= m22_s8 * c1_s8;
			ax2x_s9 <= ax2x_s8;
			ax2y_s9 <= ax2y_s8;
			ax2z_s9 <= ax2z_s8;
			deg_s9  <= deg_s8;
		end
	end

	// ---------------- s10: output register ----------------
	// axis1 = M * (c1, 0, -s1), axis3 = M * (s1, 0, c1)
	logic        valid_s10;
	dtob_basis_t basis_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else if (adv) begin
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (deg_s9) begin
				basis_s10 <= '{axis1_x: OUT_ONE, axis1_y: '0, axis1_z: '0,
					axis2_x: '0, axis2_y: OUT_ONE, axis2_z: '0,
					axis3_x: '0, axis3_y: '0, axis3_z: OUT_ONE, degenerate: 1'b1};
			end else begin
				basis_s10.axis1_x <= fx_out(fx_round(RND_W'(p00c_s9)) - fx_round(RND_W'(p02s_s9)));
				basis_s10.axis1_y <= fx_out(fx_round(RND_W'(p10c_s9)) - fx_round(RND_W'(p12s_s9)));
				basis_s10.axis1_z <= fx_out(fx_round(RND_W'(p20c_s9)) - fx_round(RND_W'(p22s_s9)));
				basis_s10.axis2_x <= ax2x_s9;
				basis_s10.axis2_y <= ax2y_s9;
				basis_s10.axis2_z <= ax2z_s9;
				basis_s10.axis3_x <= fx_out(fx_round(RND_W'(p00s_s9)) + fx_round(RND_W'(p02c_s9)));
				basis_s10.axis3_y <= fx_out(fx_round(RND_W'(p10s_s9)) + fx_round(RND_W'(p12c_s9)));
				basis_s10.axis3_z <= fx_out(fx_round(RND_W'(p20s_s9)) + fx_round(RND_W'(p22c_s9)));
				basis_s10.degenerate <= 1'b0;
			end
		end
	end

	assign out_valid = valid_s10;
	assign basis     = basis_s10;

	// ---------------- assertions ----------------
	`DTOB_ASSERT_NOW(a_deg_identity, out_valid && basis.degenerate,
		basis.axis1_x == OUT_ONE && basis.axis2_y == OUT_ONE && basis.axis3_z == OUT_ONE,
		"degenerate result is not the identity basis")
	`DTOB_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, valid_s1,
		"accepted direction did not enter the pipeline")
	`DTOB_ASSERT_NEXT(a_stall_freezes, !in_ready,
		$stable(valid_s1) && $stable(valid_s4) && $stable(valid_s9),
		"pipeline moved while the output was stalled")

endmodule
